@@ rtl/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 step function of the frame decoder.
// Used by htfd_front, htfd_queue, htfd_back and humidity_temp_frame_decoder.
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Byte position of the sensor's own CRC, which closes a reply.
  localparam logic [2:0] LAST_POS = 3'd6;

  localparam int RAW_W    = 20;
  localparam int HUM_W    = 14;
  localparam int TEMP_W   = 16;
  localparam int HSCALE_W = 14;
  localparam int TSCALE_W = 16;

  localparam logic [HSCALE_W-1:0] HUM_SCALE   = 14'd10000;
  localparam logic [TSCALE_W-1:0] TEMP_SCALE  = 16'd36000;
  localparam logic [TEMP_W-1:0]   TEMP_OFFSET = 16'd5800;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ZERO = 2'd2,
    ST_CRC  = 2'd3
  } status_t;

  // One finished reply as the front hands it to the back.
  typedef struct packed {
    status_t          status;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
  } frame_rec_t;

  // CRC-8, polynomial 0x31, MSB first, over one byte.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/htfd_front.sv @@
// Front of the frame decoder: takes reply bytes, tracks the byte position,
// runs the CRC and assembles the raw values. Depends on htfd_pkg.
module htfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic                q_full,
  output logic                full,
  output logic                rec_push,
  output htfd_pkg::frame_rec_t rec
);

  logic [2:0]                  byte_count;
  logic [7:0]                  crc_acc;
  logic                        busy_seen;
  logic                        nonzero_seen;
  logic [htfd_pkg::RAW_W-1:0]  hum_acc;
  logic [htfd_pkg::RAW_W-1:0]  temp_acc;

  logic                        accept;
  logic [2:0]                  pos;
  logic                        first;
  logic [7:0]                  crc_base;
  logic                        nz_base;
  logic [htfd_pkg::RAW_W-1:0]  hum_base;
  logic [htfd_pkg::RAW_W-1:0]  temp_base;

  // A byte is held off whenever the queue is full, even one that closes no reply.
  assign full   = q_full;
  assign accept = push && !q_full;

  assign pos   = (frame_start || byte_count == 3'd7) ? 3'd0 : byte_count;
  assign first = (pos == 3'd0);

  // Byte 0 starts from cleared accumulators and the CRC at its initial value.
  assign crc_base  = first ? htfd_pkg::CRC_INIT : crc_acc;
  assign nz_base   = first ? 1'b0 : nonzero_seen;
  assign hum_base  = first ? '0 : hum_acc;
  assign temp_base = first ? '0 : temp_acc;

  always_comb begin
    rec.hum_raw  = hum_acc;
    rec.temp_raw = temp_acc;
    if (busy_seen) begin
      rec.status = htfd_pkg::ST_BUSY;
    end else if (!nonzero_seen) begin
      rec.status = htfd_pkg::ST_ZERO;
    end else if (crc_acc != rx_byte) begin
      rec.status = htfd_pkg::ST_CRC;
    end else begin
      rec.status = htfd_pkg::ST_OK;
    end
  end

  assign rec_push = accept && (pos == htfd_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      crc_acc      <= htfd_pkg::CRC_INIT;
      busy_seen    <= 1'b0;
      nonzero_seen <= 1'b0;
      hum_acc      <= '0;
      temp_acc     <= '0;
    end else if (accept) begin
      if (pos < htfd_pkg::LAST_POS) begin
        crc_acc      <= htfd_pkg::crc_step(crc_base, rx_byte);
        nonzero_seen <= nz_base || (rx_byte != 8'd0);
        hum_acc      <= hum_base;
        temp_acc     <= temp_base;
        byte_count   <= pos + 3'd1;
      end else begin
        byte_count <= '0;
      end
      case (pos)
        3'd0: begin
          busy_seen <= rx_byte[7];
        end
        3'd1: begin
          hum_acc <= {rx_byte, 12'd0};
        end
        3'd2: begin
          hum_acc <= hum_base | {8'd0, rx_byte, 4'd0};
        end
        3'd3: begin
          hum_acc  <= hum_base | {16'd0, rx_byte[7:4]};
          temp_acc <= {rx_byte[3:0], 16'd0};
        end
        3'd4: begin
          temp_acc <= temp_base | {4'd0, rx_byte, 8'd0};
        end
        3'd5: begin
          temp_acc <= temp_base | {12'd0, rx_byte};
        end
        default: begin
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= htfd_pkg::LAST_POS)
    else $error("byte position out of range");

  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    rec_push |=> byte_count == 3'd0)
    else $error("position not cleared after the closing byte");

  a_resync: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> byte_count == 3'd1)
    else $error("frame start did not resync the position");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> !q_full)
    else $error("record pushed into a full queue");

endmodule

@@ rtl/htfd_queue.sv @@
// Two-entry queue of finished reply records between the front and the back.
// Depends on htfd_pkg.
module htfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  htfd_pkg::frame_rec_t wr_rec,
  input  logic                 rd_en,
  output htfd_pkg::frame_rec_t rd_rec,
  output logic                 q_full,
  output logic                 q_empty
);

  localparam int PTR_W = $clog2(htfd_pkg::QUEUE_DEPTH);

  htfd_pkg::frame_rec_t mem [htfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       count;

  logic do_wr;
  logic do_rd;

  assign q_full  = (count == (PTR_W+1)'(htfd_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/htfd_back.sv @@
// Back of the frame decoder: scales the raw values in a multiply stage and
// holds the finished result in an output register. Depends on htfd_pkg.
module htfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  htfd_pkg::frame_rec_t          q_rec,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    status,
  output logic [htfd_pkg::RAW_W-1:0]    humidity_raw,
  output logic [htfd_pkg::RAW_W-1:0]    temperature_raw,
  output logic [htfd_pkg::HUM_W-1:0]    humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0] temp_centi_f
);

  localparam int HP_W = htfd_pkg::RAW_W + htfd_pkg::HSCALE_W;
  localparam int TP_W = htfd_pkg::RAW_W + htfd_pkg::TSCALE_W;

  logic                          s_valid;
  htfd_pkg::frame_rec_t          s_rec;
  logic [htfd_pkg::HUM_W-1:0]    s_hum;
  logic [htfd_pkg::TEMP_W-1:0]   s_temp_f;
  logic                          o_valid;

  logic            o_free;
  logic            s_adv;
  logic [HP_W-1:0] hum_prod;
  logic [TP_W-1:0] temp_prod;

  assign o_free = !o_valid || pop;
  assign s_adv  = !s_valid || o_free;
  assign q_pop  = !q_empty && s_adv;
  assign empty  = !o_valid;

  assign hum_prod  = HP_W'(q_rec.hum_raw) * HP_W'(htfd_pkg::HUM_SCALE);
  assign temp_prod = TP_W'(q_rec.temp_raw) * TP_W'(htfd_pkg::TEMP_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (s_adv) begin
        s_valid <= q_pop;
      end
      if (o_free) begin
        o_valid <= s_valid;
      end
    end
    if (q_pop) begin
      s_rec    <= q_rec;
      s_hum    <= hum_prod[HP_W-1 -: htfd_pkg::HUM_W];
      s_temp_f <= temp_prod[TP_W-1 -: htfd_pkg::TEMP_W];
    end
    if (o_free && s_valid) begin
      status          <= 2'(s_rec.status);
      humidity_raw    <= s_rec.hum_raw;
      temperature_raw <= s_rec.temp_raw;
      humidity_centi  <= s_hum;
      temp_centi_f    <= signed'(s_temp_f - htfd_pkg::TEMP_OFFSET);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !pop |=> o_valid)
    else $error("result dropped while stalled");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s_valid && !o_free |=> s_valid)
    else $error("multiply stage lost its record");

  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> s_adv && !q_empty)
    else $error("queue popped without room");

endmodule

@@ rtl/humidity_temp_frame_decoder.sv @@
// Top level of the humidity/temperature reply decoder.
// Instantiates htfd_front, htfd_queue and htfd_back; depends on htfd_pkg.
//
// Usage:
//   Input channel: one byte of the sensor's seven-byte reply per transaction
//   (push/full). frame_start marks byte 0 and resyncs the byte position;
//   without it the byte after the closing CRC byte starts the next reply.
//   Result channel (empty/pop): one transaction per reply, produced by the
//   seventh byte, carrying the status, both raw values, humidity in hundredths
//   of a percent and temperature in hundredths of a degree Fahrenheit.
//   Throughput: one byte per cycle while full is low. The CRC step over a
//   byte is done in the same cycle the byte is taken. After the edge that
//   took the closing byte, the result passes the queue write, the multiply
//   stage and the output register on its way to the result ports.
//   The back holds a multiply stage and an output register; a two-entry queue
//   separates it from the front. When the receiver stops popping, results pile
//   up in the output register, the multiply stage and the queue; once the
//   queue is full, full rises and holds off every byte until a slot frees.
//   Reset (rst, synchronous) empties all stages and sets the byte position to
//   byte 0 with the CRC at its initial value.
module humidity_temp_frame_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [7:0]                           rx_byte,
  input  logic                                 frame_start,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [1:0]                           status,
  output logic [htfd_pkg::RAW_W-1:0]           humidity_raw,
  output logic [htfd_pkg::RAW_W-1:0]           temperature_raw,
  output logic [htfd_pkg::HUM_W-1:0]           humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0]   temp_centi_f
);

  // Records of finished replies travel from the front to the back here.
  logic                 rec_push;
  htfd_pkg::frame_rec_t rec;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  htfd_pkg::frame_rec_t q_rec;

  htfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .q_full      (q_full),
    .full        (full),
    .rec_push    (rec_push),
    .rec         (rec)
  );

  htfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_rec  (rec),
    .rd_en   (q_pop),
    .rd_rec  (q_rec),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  htfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_rec           (q_rec),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .status          (status),
    .humidity_raw    (humidity_raw),
    .temperature_raw (temperature_raw),
    .humidity_centi  (humidity_centi),
    .temp_centi_f    (temp_centi_f)
  );

endmodule
